[src/vpd_pkg.sv]
// Shared types, result codes and helpers for the VP9 payload descriptor parser.
`default_nettype none

package vpd_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DESC      = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_LAST_PAY  = 3'd2,
    KIND_RES       = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  // Flag byte bit positions (flag_bits = first byte >> 1)
  localparam int unsigned FL_I = 6;
  localparam int unsigned FL_P = 5;
  localparam int unsigned FL_L = 4;
  localparam int unsigned FL_F = 3;
  localparam int unsigned FL_B = 2;
  localparam int unsigned FL_V = 0;

  localparam logic [10:0] BYTE_COUNT_MAX = 11'd2047;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // One result item
  typedef struct packed {
    kind_t        kind;
    logic [6:0]   flags;
    logic [14:0]  picture_id;
    logic [2:0]   temporal_id;
    logic [2:0]   spatial_id;
    logic [1:0]   layer_flags;
    logic [7:0]   tl0_pic_index;
    logic         key_frame;
    logic [10:0]  header_length;
    logic [15:0]  value;
    logic [15:0]  height;
    logic [2:0]   layer_index;
  } result_t;

  // Results produced by one parsed byte, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Build a descriptor or truncated result from the parsed fields
  function automatic result_t make_desc(kind_t kind, logic [6:0] fl, logic [14:0] pic,
                                        logic [7:0] layer, logic [7:0] tl0,
                                        logic [10:0] len);
    result_t r;
    r               = '0;
    r.kind          = kind;
    r.flags         = fl;
    r.picture_id    = pic;
    r.temporal_id   = layer[7:5];
    r.spatial_id    = layer[3:1];
    r.layer_flags   = {layer[4], layer[0]};
    r.tl0_pic_index = tl0;
    r.key_frame     = fl[FL_B] & ~fl[FL_P];
    r.header_length = len;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/vpd_parser.sv]
// Descriptor parse state and per-byte decode; produces up to two results per byte.
`default_nettype none

module vpd_parser
  import vpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output push_t           push
);

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_PID1    = 12'b0000_0000_0010,
    PH_PID2    = 12'b0000_0000_0100,
    PH_LAYER   = 12'b0000_0000_1000,
    PH_TL0     = 12'b0000_0001_0000,
    PH_PDIFF   = 12'b0000_0010_0000,
    PH_SS      = 12'b0000_0100_0000,
    PH_RES     = 12'b0000_1000_0000,
    PH_GOFN    = 12'b0001_0000_0000,
    PH_GOFE    = 12'b0010_0000_0000,
    PH_GOFR    = 12'b0100_0000_0000,
    PH_PAYLOAD = 12'b1000_0000_0000
  } phase_t;

  // Skip the descriptor sections that the flags say are absent
  function automatic phase_t skip_to(phase_t st, logic [6:0] fl, logic [4:0] ss);
    phase_t p;
    p = st;
    if (p == PH_PID1 && !fl[FL_I]) p = PH_LAYER;
    if (p == PH_LAYER && !fl[FL_L]) p = PH_PDIFF;
    if (p == PH_TL0 && fl[FL_F]) p = PH_PDIFF;
    if (p == PH_PDIFF && !(fl[FL_F] && fl[FL_P])) p = PH_SS;
    if (p == PH_SS && !fl[FL_V]) p = PH_PAYLOAD;
    if (p == PH_RES && !ss[1]) p = PH_GOFN;
    if (p == PH_GOFN && !ss[0]) p = PH_PAYLOAD;
    return p;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [6:0]  flags_r, flags_nxt;
  logic [14:0] pic_r, pic_nxt;
  logic [7:0]  layer_r, layer_nxt;
  logic [7:0]  tl0_r, tl0_nxt;
  logic [4:0]  ss_r, ss_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [1:0]  rbi_r, rbi_nxt;
  logic [15:0] wh_r, wh_nxt;
  logic [15:0] hh_r, hh_nxt;
  logic [7:0]  gof_r, gof_nxt;
  logic [1:0]  refr_r, refr_nxt;
  logic [1:0]  pd_r, pd_nxt;
  logic [10:0] bc_r, bc_nxt;

  logic        tail;
  logic [1:0]  n;
  result_t     res0, res1, extra;
  logic        have_extra;

  // Per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    pic_nxt   = pic_r;
    layer_nxt = layer_r;
    tl0_nxt   = tl0_r;
    ss_nxt    = ss_r;
    lc_nxt    = lc_r;
    rbi_nxt   = rbi_r;
    wh_nxt    = wh_r;
    hh_nxt    = hh_r;
    gof_nxt   = gof_r;
    refr_nxt  = refr_r;
    pd_nxt    = pd_r;
    bc_nxt    = bc_r;
    tail      = 1'b0;
    n         = 2'd0;
    res0      = '0;
    res1      = '0;
    extra     = '0;

    if (first_byte) begin
      // Start of packet: clear everything and take the flag byte
      flags_nxt = data_byte[7:1];
      pic_nxt   = '0;
      layer_nxt = '0;
      tl0_nxt   = '0;
      ss_nxt    = '0;
      lc_nxt    = '0;
      rbi_nxt   = '0;
      wh_nxt    = '0;
      hh_nxt    = '0;
      gof_nxt   = '0;
      refr_nxt  = '0;
      pd_nxt    = '0;
      bc_nxt    = 11'd1;
      phase_nxt = skip_to(PH_PID1, data_byte[7:1], 5'd0);
      tail      = 1'b1;
    end else if (phase_r == PH_IDLE) begin
      // no packet open: byte dropped
      tail = 1'b0;
    end else if (phase_r == PH_PAYLOAD) begin
      n          = 2'd1;
      res0.kind  = last_byte ? KIND_LAST_PAY : KIND_PAYLOAD;
      res0.value = {8'd0, data_byte};
      if (last_byte) phase_nxt = PH_IDLE;
    end else begin
      if (bc_r != BYTE_COUNT_MAX) bc_nxt = bc_r + 11'd1;
      tail = 1'b1;
      case (phase_r)
        PH_PID1: begin
          pic_nxt   = {8'd0, data_byte[6:0]};
          phase_nxt = data_byte[7] ? PH_PID2 : skip_to(PH_LAYER, flags_r, ss_r);
        end
        PH_PID2: begin
          pic_nxt   = {pic_r[6:0], data_byte};
          phase_nxt = skip_to(PH_LAYER, flags_r, ss_r);
        end
        PH_LAYER: begin
          layer_nxt = data_byte;
          phase_nxt = skip_to(PH_TL0, flags_r, ss_r);
        end
        PH_TL0: begin
          tl0_nxt   = data_byte;
          phase_nxt = skip_to(PH_PDIFF, flags_r, ss_r);
        end
        PH_PDIFF: begin
          // N bit ignored on the third P_DIFF byte
          pd_nxt = pd_r + 2'd1;
          if (!data_byte[0] || pd_nxt == 2'd3) phase_nxt = skip_to(PH_SS, flags_r, ss_r);
        end
        PH_SS: begin
          ss_nxt    = data_byte[7:3];
          lc_nxt    = '0;
          rbi_nxt   = '0;
          phase_nxt = skip_to(PH_RES, flags_r, data_byte[7:3]);
        end
        PH_RES: begin
          case (rbi_r)
            2'd0:    wh_nxt = {data_byte, 8'd0};
            2'd1:    wh_nxt = {wh_r[15:8], data_byte};
            2'd2:    hh_nxt = {data_byte, 8'd0};
            default: hh_nxt = {hh_r[15:8], data_byte};
          endcase
          if (rbi_r == 2'd3) begin
            // width and height complete: one resolution result
            n                = 2'd1;
            res0.kind        = KIND_RES;
            res0.value       = wh_r;
            res0.height      = hh_nxt;
            res0.layer_index = lc_r;
            if (lc_r >= ss_r[4:2]) phase_nxt = skip_to(PH_GOFN, flags_r, ss_r);
            else lc_nxt = lc_r + 3'd1;
            rbi_nxt = '0;
          end else begin
            rbi_nxt = rbi_r + 2'd1;
          end
        end
        PH_GOFN: begin
          gof_nxt   = data_byte;
          phase_nxt = (data_byte != 8'd0) ? PH_GOFE : PH_PAYLOAD;
        end
        PH_GOFE: begin
          refr_nxt = data_byte[3:2];
          if (data_byte[3:2] != 2'd0) begin
            phase_nxt = PH_GOFR;
          end else begin
            gof_nxt   = gof_r - 8'd1;
            phase_nxt = (gof_nxt != 8'd0) ? PH_GOFE : PH_PAYLOAD;
          end
        end
        PH_GOFR: begin
          refr_nxt = refr_r - 2'd1;
          if (refr_nxt == 2'd0) begin
            gof_nxt   = gof_r - 8'd1;
            phase_nxt = (gof_nxt != 8'd0) ? PH_GOFE : PH_PAYLOAD;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          tail      = 1'b0;
        end
      endcase
    end

    // Descriptor complete, or packet ended inside it
    have_extra = 1'b0;
    if (tail) begin
      if (phase_nxt == PH_PAYLOAD) begin
        have_extra = 1'b1;
        extra = make_desc(KIND_DESC, flags_nxt, pic_nxt, layer_nxt, tl0_nxt, bc_nxt);
        if (last_byte) phase_nxt = PH_IDLE;
      end else if (last_byte) begin
        have_extra = 1'b1;
        extra = make_desc(KIND_TRUNC, flags_nxt, pic_nxt, layer_nxt, tl0_nxt, bc_nxt);
        phase_nxt = PH_IDLE;
      end
    end
    if (have_extra) begin
      if (n == 2'd0) res0 = extra;
      else res1 = extra;
      n = n + 2'd1;
    end
  end

  assign push.count = fire ? n : 2'd0;
  assign push.res0  = res0;
  assign push.res1  = res1;

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flags_r <= '0;
      pic_r   <= '0;
      layer_r <= '0;
      tl0_r   <= '0;
      ss_r    <= '0;
      lc_r    <= '0;
      rbi_r   <= '0;
      wh_r    <= '0;
      hh_r    <= '0;
      gof_r   <= '0;
      refr_r  <= '0;
      pd_r    <= '0;
      bc_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      pic_r   <= pic_nxt;
      layer_r <= layer_nxt;
      tl0_r   <= tl0_nxt;
      ss_r    <= ss_nxt;
      lc_r    <= lc_nxt;
      rbi_r   <= rbi_nxt;
      wh_r    <= wh_nxt;
      hh_r    <= hh_nxt;
      gof_r   <= gof_nxt;
      refr_r  <= refr_nxt;
      pd_r    <= pd_nxt;
      bc_r    <= bc_nxt;
    end
  end

endmodule

`default_nettype wire

[src/vpd_res_queue.sv]
// Four-entry shifting result queue: takes up to two results a cycle, gives one.
`default_nettype none

module vpd_res_queue
  import vpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    head
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  result_t         q_r   [QUEUE_DEPTH];
  result_t         q_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cnt_after;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign head      = q_r[0];
  // room for two more results regardless of the output side
  assign room      = (count_r <= CW'(QUEUE_DEPTH - 2));

  // Shift on transfer out, then append new results behind the survivors
  always_comb begin
    cnt_after = count_r - CW'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) q_nxt[i] = q_r[(i + 1) % QUEUE_DEPTH];
      else q_nxt[i] = q_r[i];
      if (push.count != 2'd0 && CW'(i) == cnt_after) q_nxt[i] = push.res0;
      if (push.count == 2'd2 && CW'(i) == cnt_after + CW'(1)) q_nxt[i] = push.res1;
    end
    count_nxt = cnt_after + CW'(push.count);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) q_r[i] <= q_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[src/vp9_payload_descriptor_parser.sv]
// Path: input register, then one combinational parse pass, then the result queue register
// that drives the output port; the input register holds its byte while the queue lacks room.
// Throughput: one byte per cycle; a byte with two results (resolution plus descriptor)
// is absorbed by a four-entry queue; the input stalls only while the queue holds three or
// more results.
// Reset (synchronous, rst_n low) empties queue and input stage; parser awaits a first byte.
`default_nettype none

module vp9_payload_descriptor_parser
  import vpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [6:0]       out_flags,
  output logic [14:0]      out_picture_id,
  output logic [2:0]       out_temporal_id,
  output logic [2:0]       out_spatial_id,
  output logic [1:0]       out_layer_flags,
  output logic [7:0]       out_tl0_pic_index,
  output logic             out_key_frame,
  output logic [10:0]      out_header_length,
  output logic [15:0]      out_value,
  output logic [15:0]      out_height,
  output logic [2:0]       out_layer_index
);

  logic        iv_r;
  logic [7:0]  ib_r;
  logic        if_r;
  logic        il_r;
  logic        room;
  logic        adv;
  push_t       push;
  result_t     head;

  // Input stage advances into the parser when the queue can take two results
  assign adv      = iv_r & room;
  assign in_ready = ~iv_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv_r <= 1'b1;
    end else if (adv) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_r <= in_data_byte;
      if_r <= in_first_byte;
      il_r <= in_last_byte;
    end
  end

  vpd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (adv),
    .data_byte  (ib_r),
    .first_byte (if_r),
    .last_byte  (il_r),
    .push       (push)
  );

  vpd_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind          = head.kind;
  assign out_flags         = head.flags;
  assign out_picture_id    = head.picture_id;
  assign out_temporal_id   = head.temporal_id;
  assign out_spatial_id    = head.spatial_id;
  assign out_layer_flags   = head.layer_flags;
  assign out_tl0_pic_index = head.tl0_pic_index;
  assign out_key_frame     = head.key_frame;
  assign out_header_length = head.header_length;
  assign out_value         = head.value;
  assign out_height        = head.height;
  assign out_layer_index   = head.layer_index;

endmodule

`default_nettype wire
